// File: hw/rtl/olir_pkg.sv
// Package with the constants, codes and types shared by the ordered list modules.
`default_nettype none
package olir_pkg;

   localparam int CAPACITY = 16;
   localparam int POS_W    = 5;
   localparam int COUNT_W  = 5;
   localparam int DATA_W   = 32;

   typedef enum logic [2:0] {
      OP_APPEND = 3'd0,
      OP_INSERT = 3'd1,
      OP_UPDATE = 3'd2,
      OP_REMOVE = 3'd3,
      OP_POP    = 3'd4,
      OP_READ   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_UPDATE = 2'd2,
      CELL_REMOVE = 2'd3
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type        kind;
      logic [POS_W-1:0]    pos;
      logic [DATA_W-1:0]   value;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// File: hw/rtl/olir_cell.sv
// One storage cell of the list chain, holding one entry and moving it to a neighbor.
`default_nettype none
module olir_cell (
   input  wire logic                          clock,
   input  wire olir_pkg::cell_ctrl_type       ctrl,
   input  wire logic [olir_pkg::POS_W-1:0]    cell_index,
   input  wire logic [olir_pkg::DATA_W-1:0]   left_data,
   input  wire logic [olir_pkg::DATA_W-1:0]   right_data,
   output logic      [olir_pkg::DATA_W-1:0]   data
);
   import olir_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.kind)
         CELL_INSERT: begin
            if (cell_index == ctrl.pos) begin
               data_in = ctrl.value;
            end else if (cell_index > ctrl.pos) begin
               data_in = left_data;
            end
         end
         CELL_UPDATE: begin
            if (cell_index == ctrl.pos) begin
               data_in = ctrl.value;
            end
         end
         CELL_REMOVE: begin
            if (cell_index >= ctrl.pos) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/olir_ctrl.sv
// Request decoder, entry counter and response register of the ordered list.
`default_nettype none
module olir_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accepted,
   input  wire logic [2:0]                    req_op,
   input  wire logic [olir_pkg::POS_W-1:0]    req_position,
   input  wire logic [olir_pkg::DATA_W-1:0]   req_value,
   input  wire logic [olir_pkg::DATA_W-1:0]   sel_data,
   output olir_pkg::cell_ctrl_type            ctrl,
   output logic                               rsp_valid,
   output logic      [olir_pkg::DATA_W-1:0]   rsp_read_value,
   output logic      [1:0]                    rsp_status,
   output logic      [olir_pkg::COUNT_W-1:0]  rsp_entry_count
);
   import olir_pkg::*;

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY);

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               valid_ff;
   logic [DATA_W-1:0]  read_ff;
   logic [DATA_W-1:0]  read_in;
   status_type         status_ff;
   status_type         status_in;

   always_comb begin
      ctrl.kind  = CELL_HOLD;
      ctrl.pos   = req_position;
      ctrl.value = req_value;
      count_in   = count_ff;
      status_in  = ST_OK;
      read_in    = '0;
      if (accepted) begin
         case (op_type'(req_op))
            OP_APPEND: begin
               if (count_ff == FULL_COUNT) begin
                  status_in = ST_FULL;
               end else begin
                  ctrl.kind = CELL_INSERT;
                  ctrl.pos  = count_ff;
                  count_in  = count_ff + COUNT_W'(1);
               end
            end
            OP_INSERT: begin
               if (req_position > count_ff) begin
                  status_in = ST_RANGE;
               end else if (count_ff == FULL_COUNT) begin
                  status_in = ST_FULL;
               end else begin
                  ctrl.kind = CELL_INSERT;
                  count_in  = count_ff + COUNT_W'(1);
               end
            end
            OP_UPDATE: begin
               if (req_position >= count_ff) begin
                  status_in = ST_RANGE;
               end else begin
                  ctrl.kind = CELL_UPDATE;
               end
            end
            OP_REMOVE: begin
               if (req_position >= count_ff) begin
                  status_in = ST_RANGE;
               end else begin
                  ctrl.kind = CELL_REMOVE;
                  count_in  = count_ff - COUNT_W'(1);
               end
            end
            OP_POP: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  count_in = count_ff - COUNT_W'(1);
               end
            end
            OP_READ: begin
               if (req_position >= count_ff) begin
                  status_in = ST_RANGE;
               end else begin
                  read_in = sel_data;
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= accepted;
      end
   end

   always_ff @(posedge clock) begin
      read_ff   <= read_in;
      status_ff <= status_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_read_value  = read_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("Entry count exceeds the capacity.");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !accepted |=> $stable(count_ff))
      else $error("Entry count changed without a request.");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accepted |=> valid_ff)
      else $error("Accepted request produced no response.");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && status_ff == ST_FULL) |-> count_ff == FULL_COUNT)
      else $error("Full status reported on a list that is not full.");

endmodule
`default_nettype wire

// File: hw/rtl/ordered_list_insert_remove.sv
// Top level of the ordered list: a chain of entry cells steered by one controller.
// The response is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle; busy stays low, as every operation shifts the
// whole cell chain together at the clock edge that accepts the request.
// Reset clears the entry count and the response strobe; entry contents stay
// undefined until written, and no clearing pass is needed.
`default_nettype none
module ordered_list_insert_remove (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic        [2:0]                    req_op,
   input  wire logic        [olir_pkg::POS_W-1:0]    req_position,
   input  wire logic signed [olir_pkg::DATA_W-1:0]   req_value,
   output logic                                      rsp_valid,
   output logic signed      [olir_pkg::DATA_W-1:0]   rsp_read_value,
   output logic             [1:0]                    rsp_status,
   output logic             [olir_pkg::COUNT_W-1:0]  rsp_entry_count
);
   import olir_pkg::*;

   cell_ctrl_type     ctrl;
   logic              accepted;
   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic [DATA_W-1:0] sel_data;

   assign busy     = 1'b0;
   assign accepted = start && !busy;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = ctrl.value;
      end else begin : g_mid
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_inner
         assign right_data = cell_data[i+1];
      end
      olir_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (POS_W'(i)),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i])
      );
   end

   always_comb begin
      sel_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (req_position == POS_W'(i)) begin
            sel_data = cell_data[i];
         end
      end
   end

   olir_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .accepted        (accepted),
      .req_op          (req_op),
      .req_position    (req_position),
      .req_value       (req_value),
      .sel_data        (sel_data),
      .ctrl            (ctrl),
      .rsp_valid       (rsp_valid),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
`default_nettype wire

// File: dv/tb_ordered_list_insert_remove.sv
`timescale 1ns / 1ps
// Testbench for the ordered list: directed table, then random request bursts checked by a predictor.
module tb_ordered_list_insert_remove;
   import olir_pkg::*;

   localparam logic [2:0] OP_UNUSED_6 = 3'd6;
   localparam logic [2:0] OP_UNUSED_7 = 3'd7;
   localparam int         RANDOM_REQUESTS = 900;
   localparam int         DRAIN_CYCLES = 4;

   typedef struct packed {
      logic signed [DATA_W-1:0] rd;
      status_type               st;
      logic [COUNT_W-1:0]       cnt;
   } list_result_type;

   typedef struct {
      logic [2:0]               op;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
      int                       rep;
      bit                       typed;
      list_result_type          res;
   } table_row_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [2:0]                 req_op;
   logic [POS_W-1:0]           req_position;
   logic signed [DATA_W-1:0]   req_value;
   logic                       rsp_valid;
   logic signed [DATA_W-1:0]   rsp_read_value;
   logic [1:0]                 rsp_status;
   logic [COUNT_W-1:0]         rsp_entry_count;

   logic signed [DATA_W-1:0]   list_mem [CAPACITY];
   logic [COUNT_W-1:0]         list_len;
   list_result_type            result_q [$];
   int                         errs = 0;

   table_row_type dir_rows [0:26] = '{
      '{OP_POP,      5'd0,  32'sd0,          1,  1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
      '{OP_READ,     5'd0,  32'sd0,          1,  1'b1, '{32'sd0, ST_RANGE, 5'd0}},
      '{OP_UPDATE,   5'd0,  32'sd1,          1,  1'b1, '{32'sd0, ST_RANGE, 5'd0}},
      '{OP_REMOVE,   5'd0,  32'sd0,          1,  1'b1, '{32'sd0, ST_RANGE, 5'd0}},
      '{OP_INSERT,   5'd1,  32'sd2,          1,  1'b1, '{32'sd0, ST_RANGE, 5'd0}},
      '{OP_UNUSED_6, 5'd3,  32'sd3,          1,  1'b1, '{32'sd0, ST_OK,    5'd0}},
      '{OP_UNUSED_7, 5'd31, -32'sd1,         1,  1'b1, '{32'sd0, ST_OK,    5'd0}},
      '{OP_APPEND,   5'd0,  32'h7FFF_FFFF,   1,  1'b1, '{32'sd0, ST_OK,    5'd1}},
      '{OP_APPEND,   5'd31, 32'h8000_0000,   1,  1'b1, '{32'sd0, ST_OK,    5'd2}},
      '{OP_READ,     5'd0,  32'sd0,          1,  1'b1, '{32'h7FFF_FFFF, ST_OK, 5'd2}},
      '{OP_READ,     5'd1,  32'sd0,          1,  1'b1, '{32'h8000_0000, ST_OK, 5'd2}},
      '{OP_INSERT,   5'd0,  -32'sd1,         1,  1'b1, '{32'sd0, ST_OK,    5'd3}},
      '{OP_INSERT,   5'd3,  32'sd0,          1,  1'b1, '{32'sd0, ST_OK,    5'd4}},
      '{OP_INSERT,   5'd31, 32'sd7,          1,  1'b1, '{32'sd0, ST_RANGE, 5'd4}},
      '{OP_READ,     5'd4,  32'sd0,          1,  1'b1, '{32'sd0, ST_RANGE, 5'd4}},
      '{OP_UPDATE,   5'd1,  32'h1234_5678,   1,  1'b0, '{32'sd0, ST_OK,    5'd0}},
      '{OP_REMOVE,   5'd0,  32'sd0,          1,  1'b0, '{32'sd0, ST_OK,    5'd0}},
      '{OP_READ,     5'd0,  32'sd0,          1,  1'b0, '{32'sd0, ST_OK,    5'd0}},
      '{OP_APPEND,   5'd0,  32'h0000_1000,   13, 1'b0, '{32'sd0, ST_OK,    5'd0}},
      '{OP_APPEND,   5'd0,  32'sd9,          1,  1'b1, '{32'sd0, ST_FULL,  5'd16}},
      '{OP_INSERT,   5'd16, 32'sd9,          1,  1'b1, '{32'sd0, ST_FULL,  5'd16}},
      '{OP_INSERT,   5'd17, 32'sd9,          1,  1'b1, '{32'sd0, ST_RANGE, 5'd16}},
      '{OP_READ,     5'd15, 32'sd0,          1,  1'b0, '{32'sd0, ST_OK,    5'd0}},
      '{OP_READ,     5'd16, 32'sd0,          1,  1'b1, '{32'sd0, ST_RANGE, 5'd16}},
      '{OP_REMOVE,   5'd15, 32'sd0,          1,  1'b0, '{32'sd0, ST_OK,    5'd0}},
      '{OP_POP,      5'd0,  32'sd0,          15, 1'b0, '{32'sd0, ST_OK,    5'd0}},
      '{OP_POP,      5'd0,  32'sd0,          1,  1'b1, '{32'sd0, ST_EMPTY, 5'd0}}
   };

   ordered_list_insert_remove u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic list_result_type apply_list_op(input logic [2:0] op,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic signed [DATA_W-1:0] val);
      list_result_type res;
      int i;
      res = '{32'sd0, ST_OK, 5'd0};
      case (op)
         OP_APPEND: begin
            if (list_len >= CAPACITY) begin
               res.st = ST_FULL;
            end else begin
               list_mem[list_len] = val;
               list_len++;
            end
         end
         OP_INSERT: begin
            if (pos > list_len) begin
               res.st = ST_RANGE;
            end else if (list_len >= CAPACITY) begin
               res.st = ST_FULL;
            end else begin
               for (i = int'(list_len); i > int'(pos); i--) list_mem[i] = list_mem[i-1];
               list_mem[pos] = val;
               list_len++;
            end
         end
         OP_UPDATE: begin
            if (pos >= list_len) res.st = ST_RANGE;
            else list_mem[pos] = val;
         end
         OP_REMOVE: begin
            if (pos >= list_len) begin
               res.st = ST_RANGE;
            end else begin
               for (i = int'(pos); i + 1 < int'(list_len); i++) list_mem[i] = list_mem[i+1];
               list_len--;
            end
         end
         OP_POP: begin
            if (list_len == 0) res.st = ST_EMPTY;
            else list_len--;
         end
         OP_READ: begin
            if (pos >= list_len) res.st = ST_RANGE;
            else res.rd = list_mem[pos];
         end
         default: begin
         end
      endcase
      res.cnt = list_len;
      return res;
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_value();
      logic signed [DATA_W-1:0] v;
      v = $urandom();
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = 32'sd0;
            default: v = -32'sd1;
         endcase
      end
      return v;
   endfunction

   // Called at a falling edge; returns at the falling edge where the next request may be driven.
   task automatic send_request(input logic [2:0] op, input logic [POS_W-1:0] pos,
                               input logic signed [DATA_W-1:0] val, input bit typed,
                               input list_result_type typed_res, input bit no_gap);
      list_result_type predicted;
      int gap;
      req_op       <= op;
      req_position <= pos;
      req_value    <= val;
      start        <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = apply_list_op(op, pos, val);
      result_q.push_back(typed ? typed_res : predicted);
      gap = no_gap ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         start     <= 1'b0;
         req_op    <= 3'($urandom());
         req_value <= $urandom();
         repeat (gap - 1) @(negedge clock);
         @(negedge clock);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      list_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (result_q.size() == 0) begin
            $error("response with no request outstanding");
            errs++;
         end else begin
            exp_res = result_q.pop_front();
            if (rsp_read_value !== exp_res.rd) begin
               $error("read_value: expected %0d, actual %0d", exp_res.rd, rsp_read_value);
               errs++;
            end
            if (rsp_status !== exp_res.st) begin
               $error("status: expected %0d, actual %0d", exp_res.st, rsp_status);
               errs++;
            end
            if (rsp_entry_count !== exp_res.cnt) begin
               $error("entry_count: expected %0d, actual %0d", exp_res.cnt, rsp_entry_count);
               errs++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("ordered_list_insert_remove test failed");
      $finish;
   end

   initial begin : stimulus
      logic [2:0]               op;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] val;
      logic [POS_W-1:0]         valid_pos;
      int                       sent;
      int                       mode;
      int                       burst_len;
      int                       r;
      int                       k;
      bit                       quiet;
      reset        = 1'b1;
      start        = 1'b0;
      req_op       = OP_APPEND;
      req_position = '0;
      req_value    = '0;
      list_len     = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[n]) begin
         for (k = 0; k < dir_rows[n].rep; k++) begin
            send_request(dir_rows[n].op, dir_rows[n].pos, dir_rows[n].value + k,
                         dir_rows[n].typed, dir_rows[n].res, 1'b0);
         end
      end

      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         mode      = $urandom_range(0, 9);
         burst_len = $urandom_range(8, 40);
         quiet     = ($urandom_range(0, 3) == 0);
         repeat (burst_len) begin
            val       = rand_value();
            valid_pos = (list_len == 0) ? '0 : POS_W'($urandom_range(0, list_len - 1));
            r         = $urandom_range(0, 9);
            case (mode)
               0, 1, 2: begin
                  if (r < 5) op = OP_APPEND;
                  else if (r < 9) op = OP_INSERT;
                  else op = OP_POP;
                  pos = POS_W'($urandom_range(0, list_len));
               end
               3, 4, 5: begin
                  if (r < 5) op = OP_REMOVE;
                  else if (r < 8) op = OP_POP;
                  else op = OP_READ;
                  pos = valid_pos;
               end
               6, 7: begin
                  if (r < 4) op = OP_READ;
                  else if (r < 8) op = OP_UPDATE;
                  else if (r < 9) op = OP_INSERT;
                  else op = OP_REMOVE;
                  pos = valid_pos;
               end
               8: begin
                  op  = 3'($urandom_range(0, 7));
                  pos = POS_W'($urandom_range(0, 31));
                  val = $urandom();
               end
               default: begin
                  op  = 3'($urandom_range(OP_APPEND, OP_READ));
                  pos = (list_len == 0) ? POS_W'($urandom_range(0, 1))
                                        : POS_W'(list_len + $urandom_range(0, 2) - 1);
               end
            endcase
            send_request(op, pos, val, 1'b0, '0, quiet);
            if (op <= OP_READ) sent++;
         end
      end

      start <= 1'b0;
      while (result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errs == 0) begin
         $display("ordered_list_insert_remove test passed");
      end else begin
         $display("ordered_list_insert_remove test failed");
      end
      $finish;
   end

endmodule
